>>> sv/dynamic_priority_scheduler_defines.svh
// Assertion helpers for the scheduler checker.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

>>> sv/dps_pkg.sv
`timescale 1ns / 1ps

package dps_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   localparam int ID_W     = 16;
   localparam int PRIO_W   = 8;
   localparam int LEN_W    = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

   // operation field
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // status field
   localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SERVED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   // ranking update kinds
   localparam logic [1:0] RK_NONE    = 2'd0;
   localparam logic [1:0] RK_ADD     = 2'd1;
   localparam logic [1:0] RK_REQUEUE = 2'd2;
   localparam logic [1:0] RK_RETIRE  = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] need;
      logic [LEN_W-1:0] done;
   } entry_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] prio;
   } rank_cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] free;
      logic [CNT_W-1:0]  occ;
   } rank_stat_type;

endpackage

>>> sv/dps_entry_ram.sv
`timescale 1ns / 1ps

module dps_entry_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [dps_pkg::SLOT_W-1:0] wr_addr,
   input  dps_pkg::entry_type         wr_data,
   input  logic                       rd_en,
   input  logic [dps_pkg::SLOT_W-1:0] rd_addr,
   output dps_pkg::entry_type         rd_data
);

   dps_pkg::entry_type entry_mem [dps_pkg::NUM_SLOTS];
   dps_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/dps_rank.sv
`timescale 1ns / 1ps

module dps_rank (
   input  logic                   clock,
   input  logic                   reset,
   input  dps_pkg::rank_cmd_type  cmd,
   output dps_pkg::rank_stat_type stat
);

   logic [dps_pkg::NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [dps_pkg::PRIO_W-1:0]    prio_ff  [dps_pkg::NUM_SLOTS];
   logic [dps_pkg::PRIO_W-1:0]    prio_in  [dps_pkg::NUM_SLOTS];
   logic [dps_pkg::SLOT_W-1:0]    order_ff [dps_pkg::NUM_SLOTS];
   logic [dps_pkg::SLOT_W-1:0]    order_in [dps_pkg::NUM_SLOTS];
   logic [dps_pkg::CNT_W-1:0]     occ_ff, occ_in;

   logic [dps_pkg::SLOT_W-1:0] head_idx, free_idx;
   logic [dps_pkg::PRIO_W-1:0] cur_prio, new_prio;
   logic [dps_pkg::CNT_W-1:0]  pos_cnt;
   logic [dps_pkg::SLOT_W-1:0] pos;

   // head: valid entry of rank zero; free: lowest invalid slot
   always_comb begin
      head_idx = '0;
      free_idx = '0;
      for (int i = dps_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (order_ff[i] == '0)) begin
            head_idx = dps_pkg::SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = dps_pkg::SLOT_W'(i);
         end
      end
   end

   // insertion rank: behind every other valid entry with number <= own
   always_comb begin
      cur_prio = prio_ff[cmd.slot];
      if (cmd.kind == dps_pkg::RK_REQUEUE) begin
         new_prio = (cur_prio == dps_pkg::PRIO_MAX) ? cur_prio : cur_prio + 1'b1;
      end else begin
         new_prio = cmd.prio;
      end
      pos_cnt = '0;
      for (int i = 0; i < dps_pkg::NUM_SLOTS; i++) begin
         if (valid_ff[i] && (dps_pkg::SLOT_W'(i) != cmd.slot) && (prio_ff[i] <= new_prio)) begin
            pos_cnt = pos_cnt + 1'b1;
         end
      end
      pos = dps_pkg::SLOT_W'(pos_cnt);
   end

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      order_in = order_ff;
      occ_in   = occ_ff;
      unique case (cmd.kind)
         dps_pkg::RK_NONE: begin
         end
         dps_pkg::RK_ADD: begin
            for (int i = 0; i < dps_pkg::NUM_SLOTS; i++) begin
               if (valid_ff[i] && (dps_pkg::SLOT_W'(i) != cmd.slot) && (order_ff[i] >= pos)) begin
                  order_in[i] = order_ff[i] + 1'b1;
               end
            end
            valid_in[cmd.slot] = 1'b1;
            prio_in[cmd.slot]  = new_prio;
            order_in[cmd.slot] = pos;
            occ_in             = occ_ff + 1'b1;
         end
         dps_pkg::RK_REQUEUE: begin
            // drop the head, then open a gap at pos: ranks up to pos move up
            for (int i = 0; i < dps_pkg::NUM_SLOTS; i++) begin
               if (valid_ff[i] && (dps_pkg::SLOT_W'(i) != cmd.slot) && (order_ff[i] <= pos)) begin
                  order_in[i] = order_ff[i] - 1'b1;
               end
            end
            prio_in[cmd.slot]  = new_prio;
            order_in[cmd.slot] = pos;
         end
         dps_pkg::RK_RETIRE: begin
            for (int i = 0; i < dps_pkg::NUM_SLOTS; i++) begin
               if (valid_ff[i] && (dps_pkg::SLOT_W'(i) != cmd.slot) && (order_ff[i] != '0)) begin
                  order_in[i] = order_ff[i] - 1'b1;
               end
            end
            valid_in[cmd.slot] = 1'b0;
            occ_in             = occ_ff - 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff  <= prio_in;
      order_ff <= order_in;
   end

   assign stat.head = head_idx;
   assign stat.free = free_idx;
   assign stat.occ  = occ_ff;

endmodule

>>> sv/dynamic_priority_scheduler.sv
// Channel   Direction  Ports                                         Word
// req       in         req_valid/req_ready                           operation, id, prio, length
// rsp       out        rsp_valid/rsp_ready                           status, id, remaining, fin, occ
//
// Each word is handled in two steps: the accept edge reads the head entry from the
// entry RAM (registered read), the next edge checks the word, writes the entry RAM,
// updates the rank registers and loads the result register.
// Reset clears the valid bits and the fill count; there is no clearing pass.
// A result left waiting holds req_ready low until rsp_ready takes it; a new
// word is accepted in the same cycle the old result is taken.
`timescale 1ns / 1ps

module dynamic_priority_scheduler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [dps_pkg::ID_W-1:0]     req_proc_id,
   input  logic [dps_pkg::PRIO_W-1:0]   req_prio_in,
   input  logic [dps_pkg::LEN_W-1:0]    req_run_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dps_pkg::STATUS_W-1:0] rsp_status,
   output logic [dps_pkg::ID_W-1:0]     rsp_served_id,
   output logic [dps_pkg::LEN_W-1:0]    rsp_remaining,
   output logic                         rsp_finished,
   output logic [dps_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam logic PH_IDLE = 1'b0;
   localparam logic PH_EXEC = 1'b1;

   logic phase_ff, phase_in;
   logic req_fire, exec;

   // captured request word
   logic                       op_ff;
   logic [dps_pkg::ID_W-1:0]   id_ff;
   logic [dps_pkg::PRIO_W-1:0] prio_ff;
   logic [dps_pkg::LEN_W-1:0]  len_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dps_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [dps_pkg::ID_W-1:0]     rsp_served_id_ff, rsp_served_id_in;
   logic [dps_pkg::LEN_W-1:0]    rsp_remaining_ff, rsp_remaining_in;
   logic                         rsp_finished_ff, rsp_finished_in;
   logic [dps_pkg::OCC_W-1:0]    rsp_occupancy_ff, rsp_occupancy_in;

   dps_pkg::rank_cmd_type  rank_cmd;
   dps_pkg::rank_stat_type rank_stat;

   logic                       wr_en;
   logic [dps_pkg::SLOT_W-1:0] wr_addr;
   dps_pkg::entry_type         wr_data;
   dps_pkg::entry_type         rd_data;

   logic [dps_pkg::LEN_W:0]   done_inc;
   logic [dps_pkg::CNT_W-1:0] occ_after;

   // Accept only when idle and the result register is empty or being drained.
   assign req_ready = (phase_ff == PH_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign exec      = (phase_ff == PH_EXEC);

   // Rank registers stay put between accept and execute, so the head index seen at accept
   // addresses the RAM read, and head and free index are still valid at execute.
   dps_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (rank_stat.head),
      .rd_data (rd_data)
   );

   dps_rank u_rank (
      .clock (clock),
      .reset (reset),
      .cmd   (rank_cmd),
      .stat  (rank_stat)
   );

   always_comb begin
      rank_cmd.kind    = dps_pkg::RK_NONE;
      rank_cmd.slot    = rank_stat.head;
      rank_cmd.prio    = prio_ff;
      wr_en            = 1'b0;
      wr_addr          = rank_stat.head;
      wr_data          = rd_data;
      done_inc         = {1'b0, rd_data.done} + 1'b1;
      occ_after        = rank_stat.occ;
      rsp_status_in    = dps_pkg::ST_ADDED;
      rsp_served_id_in = '0;
      rsp_remaining_in = '0;
      rsp_finished_in  = 1'b0;

      if (exec) begin
         if (op_ff == dps_pkg::OP_ADD) begin
            if (rank_stat.occ == dps_pkg::CNT_W'(dps_pkg::NUM_SLOTS)) begin
               rsp_status_in = dps_pkg::ST_FULL;
            end else begin
               // new entry goes to the lowest free slot with no work done
               wr_en         = 1'b1;
               wr_addr       = rank_stat.free;
               wr_data.id    = id_ff;
               wr_data.need  = len_ff;
               wr_data.done  = '0;
               rank_cmd.kind = dps_pkg::RK_ADD;
               rank_cmd.slot = rank_stat.free;
               occ_after     = rank_stat.occ + 1'b1;
            end
         end else if (rank_stat.occ == '0) begin
            rsp_status_in = dps_pkg::ST_EMPTY;
         end else begin
            rsp_status_in    = dps_pkg::ST_SERVED;
            rsp_served_id_in = rd_data.id;
            // zero run length also finishes here, since done_inc is at least 1
            if (done_inc >= {1'b0, rd_data.need}) begin
               rsp_finished_in = 1'b1;
               rank_cmd.kind   = dps_pkg::RK_RETIRE;
               occ_after       = rank_stat.occ - 1'b1;
            end else begin
               rsp_remaining_in = rd_data.need - done_inc[dps_pkg::LEN_W-1:0];
               wr_en            = 1'b1;
               wr_data.done     = done_inc[dps_pkg::LEN_W-1:0];
               rank_cmd.kind    = dps_pkg::RK_REQUEUE;
            end
         end
      end
      rsp_occupancy_in = dps_pkg::OCC_W'(occ_after);
   end

   always_comb begin
      priority if (req_fire) begin
         phase_in = PH_EXEC;
      end else if (exec) begin
         phase_in = PH_IDLE;
      end else begin
         phase_in = phase_ff;
      end
   end

   // hold the result until taken; execute always finds the register empty
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_operation;
         id_ff   <= req_proc_id;
         prio_ff <= req_prio_in;
         len_ff  <= req_run_length;
      end
      if (exec) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_served_id_ff <= rsp_served_id_in;
         rsp_remaining_ff <= rsp_remaining_in;
         rsp_finished_ff  <= rsp_finished_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_served_id = rsp_served_id_ff;
   assign rsp_remaining = rsp_remaining_ff;
   assign rsp_finished  = rsp_finished_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

>>> sv/dps_checker.sv
`timescale 1ns / 1ps
`include "dynamic_priority_scheduler_defines.svh"

module dps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_operation,
   input logic [dps_pkg::ID_W-1:0]     req_proc_id,
   input logic [dps_pkg::PRIO_W-1:0]   req_prio_in,
   input logic [dps_pkg::LEN_W-1:0]    req_run_length,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dps_pkg::STATUS_W-1:0] rsp_status,
   input logic [dps_pkg::ID_W-1:0]     rsp_served_id,
   input logic [dps_pkg::LEN_W-1:0]    rsp_remaining,
   input logic                         rsp_finished,
   input logic [dps_pkg::OCC_W-1:0]    rsp_occupancy
);

   logic req_fire;
   logic req_unused;

   assign req_fire   = req_valid && req_ready;
   assign req_unused = ^{req_operation, req_proc_id, req_prio_in, req_run_length};

   // a stalled result word holds
   `DPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_served_id) && $stable(rsp_remaining) && $stable(rsp_occupancy))

   // one word in flight: no accept right after an accept
   `DPS_ASSERT_NEXT(a_one_in_flight, req_fire && (req_unused || !req_unused), !req_ready)

   // a rejected add reports a full table
   `DPS_ASSERT_SAME(a_full_occ, rsp_valid && (rsp_status == dps_pkg::ST_FULL), rsp_occupancy == dps_pkg::OCC_W'(dps_pkg::NUM_SLOTS))

   // an empty tick reports nothing served
   `DPS_ASSERT_SAME(a_empty_zero, rsp_valid && (rsp_status == dps_pkg::ST_EMPTY), (rsp_occupancy == '0) && (rsp_served_id == '0) && !rsp_finished)

   // a finished process was served and has nothing left
   `DPS_ASSERT_SAME(a_fin_served, rsp_valid && rsp_finished, (rsp_status == dps_pkg::ST_SERVED) && (rsp_remaining == '0))

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (.*);
